// ===== rtl/core/hprgba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hprgba_pkg: shared types and constants
// Pixel format codes, payload structs and the half-to-single widening helpers.
// ----------------------------------------------------------------------------
package hprgba_pkg;

    localparam logic [2:0] FMT_GBR_F32  = 3'd0;
    localparam logic [2:0] FMT_GBRA_F32 = 3'd1;
    localparam logic [2:0] FMT_GBR_F16  = 3'd2;
    localparam logic [2:0] FMT_GBRA_F16 = 3'd3;
    localparam logic [2:0] FMT_RGB_F32  = 3'd4;
    localparam logic [2:0] FMT_RGBA_F32 = 3'd5;
    localparam logic [2:0] FMT_RGBA_F16 = 3'd6;
    localparam logic [2:0] FMT_GRAY_F32 = 3'd7;

    localparam logic [31:0] ONE_F32   = 32'h3F80_0000;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] INF_F32   = 32'h7F80_0000;

    typedef struct packed {
        logic [31:0] chan_word_0;
        logic [31:0] chan_word_1;
        logic [31:0] chan_word_2;
        logic [31:0] chan_word_3;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] red_out;
        logic [31:0] green_out;
        logic [31:0] blue_out;
        logic [31:0] alpha_out;
    } t_out_beat;

    // Decoded half: class flags plus leading-one position for subnormals.
    typedef struct packed {
        logic        sign;
        logic        is_zero;
        logic        is_sub;
        logic        is_inf;
        logic        is_nan;
        logic [4:0]  expo;
        logic [9:0]  frac;
        logic [3:0]  top;
    } t_half_dec;

    function automatic t_half_dec half_decode(input logic [15:0] h);
        t_half_dec d;
        d.sign    = h[15];
        d.expo    = h[14:10];
        d.frac    = h[9:0];
        d.is_zero = (h[14:10] == 5'd0) && (h[9:0] == 10'd0);
        d.is_sub  = (h[14:10] == 5'd0) && (h[9:0] != 10'd0);
        d.is_inf  = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
        d.is_nan  = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
        d.top     = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (h[i]) d.top = 4'(i);
        end
        return d;
    endfunction

    function automatic logic [31:0] half_pack(input t_half_dec d);
        logic [31:0] res;
        logic [22:0] mant;
        logic [22:0] fr;
        fr   = {13'd0, d.frac};
        mant = fr << (5'd23 - {1'b0, d.top});
        if (d.is_zero) begin
            res = {d.sign, 31'd0};
        end else if (d.is_sub) begin
            res = {d.sign, 8'({4'd0, d.top} + 8'd103), mant};
        end else if (d.is_inf) begin
            res = {d.sign, INF_F32[30:0]};
        end else if (d.is_nan) begin
            res = CANON_NAN;
        end else begin
            res = {d.sign, 8'({3'd0, d.expo} + 8'd112), d.frac, 13'd0};
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/hprgba_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hprgba_pipe: three-stage conversion pipeline
// Stage 1 registers input and format, stage 2 decodes halves, stage 3 packs
// and routes channels; valid bits go with data, stalls hold only full stages.
// ----------------------------------------------------------------------------
module hprgba_pipe (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [2:0]            i_fmt,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  hprgba_pkg::t_in_beat  i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output hprgba_pkg::t_out_beat o_data
);

    logic                  r_v1, r_v2, r_v3;
    hprgba_pkg::t_in_beat  r_d1;
    logic [2:0]            r_f1, r_f2;
    logic [31:0]           r_w2 [4];
    hprgba_pkg::t_half_dec r_h2 [4];
    hprgba_pkg::t_out_beat r_o3;
    hprgba_pkg::t_out_beat n_o3;
    logic                  adv3, adv2, adv1;
    logic [31:0]           cw [4];

    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v3;
    assign o_data  = r_o3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_d1 <= i_data;
            r_f1 <= i_fmt;
        end
        if (adv2) begin
            r_f2    <= r_f1;
            r_w2[0] <= r_d1.chan_word_0;
            r_w2[1] <= r_d1.chan_word_1;
            r_w2[2] <= r_d1.chan_word_2;
            r_w2[3] <= r_d1.chan_word_3;
            r_h2[0] <= hprgba_pkg::half_decode(r_d1.chan_word_0[15:0]);
            r_h2[1] <= hprgba_pkg::half_decode(r_d1.chan_word_1[15:0]);
            r_h2[2] <= hprgba_pkg::half_decode(r_d1.chan_word_2[15:0]);
            r_h2[3] <= hprgba_pkg::half_decode(r_d1.chan_word_3[15:0]);
        end
        if (adv3) r_o3 <= n_o3;
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (r_f2 == hprgba_pkg::FMT_GBR_F16 || r_f2 == hprgba_pkg::FMT_GBRA_F16 ||
                r_f2 == hprgba_pkg::FMT_RGBA_F16) begin
                cw[i] = hprgba_pkg::half_pack(r_h2[i]);
            end else begin
                cw[i] = r_w2[i];
            end
        end
        case (r_f2)
            hprgba_pkg::FMT_GBR_F32, hprgba_pkg::FMT_GBR_F16: begin
                n_o3 = '{red_out: cw[2], green_out: cw[0], blue_out: cw[1],
                         alpha_out: hprgba_pkg::ONE_F32};
            end
            hprgba_pkg::FMT_GBRA_F32, hprgba_pkg::FMT_GBRA_F16: begin
                n_o3 = '{red_out: cw[2], green_out: cw[0], blue_out: cw[1],
                         alpha_out: cw[3]};
            end
            hprgba_pkg::FMT_RGB_F32: begin
                n_o3 = '{red_out: cw[0], green_out: cw[1], blue_out: cw[2],
                         alpha_out: hprgba_pkg::ONE_F32};
            end
            hprgba_pkg::FMT_RGBA_F32, hprgba_pkg::FMT_RGBA_F16: begin
                n_o3 = '{red_out: cw[0], green_out: cw[1], blue_out: cw[2],
                         alpha_out: cw[3]};
            end
            default: begin
                n_o3 = '{red_out: cw[0], green_out: cw[0], blue_out: cw[0],
                         alpha_out: hprgba_pkg::ONE_F32};
            end
        endcase
    end

endmodule

// ===== rtl/core/hdr_pixel_to_rgba_float_unit.sv =====
`timescale 1ns / 1ps
// Three register stages lie between the input beat and the output beat.
// Throughput: one pixel per cycle; the pipeline only holds when the output
// is stalled, and each stage refills as soon as its successor moves.
// Reset: synchronous active-low i_rst_n clears stage valids and sets
// r_fmt to 0 (planar GBR float32).
// ----------------------------------------------------------------------------
// hdr_pixel_to_rgba_float_unit: pixel to RGBA float32 converter
// APB register for the source format plus the conversion pipeline.
// ----------------------------------------------------------------------------
module hdr_pixel_to_rgba_float_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // APB register port, one register at address 0
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [1:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // pixel input beats
    input  logic                  i_valid,
    output logic                  o_ready,
    input  hprgba_pkg::t_in_beat  i_data,
    // RGBA output beats
    output logic                  o_valid,
    input  logic                  i_ready,
    output hprgba_pkg::t_out_beat o_data
);

    logic [2:0] r_fmt;
    logic       wr_en;

    // Only word address 0 decodes; other addresses are ignored on write.
    assign wr_en  = psel && penable && pwrite && (paddr == 2'd0);
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {29'd0, r_fmt} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= hprgba_pkg::FMT_GBR_F32;
        end else if (wr_en) begin
            r_fmt <= pwdata[2:0];
        end
    end

    hprgba_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fmt   (r_fmt),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: pixel to RGBA float32 converter testbench
// Drives pixel beats in every source format and compares each RGBA beat with
// a widening/reordering predictor; APB writes switch formats between phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DRAIN_CYCLES = 8;     // pipeline is 3 deep
    localparam int STALL_LIMIT  = 5000;  // cycles with no beat moving

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [1:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  i_valid;
    logic                  o_ready;
    hprgba_pkg::t_in_beat  i_data;
    logic                  o_valid;
    logic                  i_ready;
    hprgba_pkg::t_out_beat o_data;

    hdr_pixel_to_rgba_float_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // Predictor state: the format last written over APB.
    logic [2:0]            cur_format;
    hprgba_pkg::t_out_beat pending_rgba[$];
    int                    fail_count;
    int                    idle_count;
    // Idle percentage for each side; zero gives a stretch with no gaps.
    int                    send_idle_pct;
    int                    recv_idle_pct;
    bit                    recv_hold;       // receiver holds off completely
    int                    hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Exact half to single widening; all half NaNs collapse to the canonical one.
    function automatic logic [31:0] widen_half(input logic [31:0] word);
        logic [15:0] h;
        logic [31:0] sgn;
        logic [4:0]  ex;
        logic [9:0]  fr;
        int          lead;
        h    = word[15:0];
        sgn  = {h[15], 31'd0};
        ex   = h[14:10];
        fr   = h[9:0];
        lead = 0;
        if (ex == 5'd0) begin
            if (fr == 10'd0) return sgn;
            for (int k = 0; k < 10; k++) if (fr[k]) lead = k;
            return sgn | (32'(lead + 103) << 23) | ((32'(fr) << (23 - lead)) & 32'h7F_FFFF);
        end
        if (ex == 5'h1F) return (fr == 10'd0) ? (sgn | 32'h7F80_0000) : 32'h7FC0_0000;
        return sgn | (32'(ex + 112) << 23) | (32'(fr) << 13);
    endfunction

    function automatic hprgba_pkg::t_out_beat convert_pixel(input hprgba_pkg::t_in_beat px,
                                                            input logic [2:0] fmt);
        hprgba_pkg::t_out_beat o;
        case (fmt)
            hprgba_pkg::FMT_GBR_F32: begin
                o = '{px.chan_word_2, px.chan_word_0, px.chan_word_1, 32'h3F80_0000};
            end
            hprgba_pkg::FMT_GBRA_F32: begin
                o = '{px.chan_word_2, px.chan_word_0, px.chan_word_1, px.chan_word_3};
            end
            hprgba_pkg::FMT_GBR_F16: begin
                o = '{widen_half(px.chan_word_2), widen_half(px.chan_word_0),
                      widen_half(px.chan_word_1), 32'h3F80_0000};
            end
            hprgba_pkg::FMT_GBRA_F16: begin
                o = '{widen_half(px.chan_word_2), widen_half(px.chan_word_0),
                      widen_half(px.chan_word_1), widen_half(px.chan_word_3)};
            end
            hprgba_pkg::FMT_RGB_F32: begin
                o = '{px.chan_word_0, px.chan_word_1, px.chan_word_2, 32'h3F80_0000};
            end
            hprgba_pkg::FMT_RGBA_F32: begin
                o = '{px.chan_word_0, px.chan_word_1, px.chan_word_2, px.chan_word_3};
            end
            hprgba_pkg::FMT_RGBA_F16: begin
                o = '{widen_half(px.chan_word_0), widen_half(px.chan_word_1),
                      widen_half(px.chan_word_2), widen_half(px.chan_word_3)};
            end
            default: begin
                o = '{px.chan_word_0, px.chan_word_0, px.chan_word_0, 32'h3F80_0000};
            end
        endcase
        return o;
    endfunction

    // Sends one pixel beat; valid stays high while the next beat follows directly.
    task automatic send_pixel(input hprgba_pkg::t_in_beat px);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= px;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_rgba.push_back(convert_pixel(px, cur_format));
        @(negedge i_clk);
    endtask

    // Idle point: waits for every outstanding beat, then the pipeline drain.
    task automatic wait_drained;
        i_valid <= 1'b0;
        while (pending_rgba.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup phase then access phase; pready is tied high.
    task automatic write_format(input logic [31:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'd0;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_format = value[2:0];
    endtask

    function automatic logic [31:0] rand_half_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(5))
            0: w[14:10] = 5'd0;          // zero or subnormal
            1: w[14:10] = 5'h1F;         // infinity or NaN
            2: w[14:0]  = 15'h7C00;      // infinity exactly
            3: w[14:0]  = 15'd0;         // signed zero
            default: ;
        endcase
        return w;
    endfunction

    function automatic hprgba_pkg::t_in_beat rand_pixel();
        hprgba_pkg::t_in_beat px;
        px.chan_word_0 = $urandom_range(1) ? rand_half_word() : $urandom();
        px.chan_word_1 = $urandom_range(1) ? rand_half_word() : $urandom();
        px.chan_word_2 = $urandom_range(1) ? rand_half_word() : $urandom();
        px.chan_word_3 = $urandom_range(1) ? rand_half_word() : $urandom();
        return px;
    endfunction

    // Directed: reset format, field extremes, and every half class.
    task automatic test_directed_halves;
        logic [15:0] specials[12] = '{16'h0000, 16'h8000, 16'h0001, 16'h8200, 16'h03FF,
                                      16'h0400, 16'h7BFF, 16'h7C00, 16'hFC00, 16'h7C01,
                                      16'hFE00, 16'h3C00};
        hprgba_pkg::t_in_beat px;
        // After reset the format is planar GBR float32.
        send_pixel('{32'hFFFF_FFFF, 32'h0000_0000, 32'h7FC0_1234, 32'h5555_AAAA});
        write_format({29'h1FFF_FFFF, hprgba_pkg::FMT_GBRA_F16});   // upper bits ignored
        for (int k = 0; k < 12; k += 4) begin
            px = '{{16'hFFFF, specials[k]}, {16'h0000, specials[k+1]},
                   {16'hA5A5, specials[k+2]}, {16'h5A5A, specials[k+3]}};
            send_pixel(px);
        end
        for (int f = 0; f < 8; f++) begin
            write_format(32'(f));
            send_pixel('{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000});
            send_pixel('{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF});
        end
    endtask

    // Random pixels in every format, idling on both sides except in format 3.
    task automatic test_random_formats;
        for (int f = 0; f < 8; f++) begin
            write_format({8'($urandom_range(8'hFF, 0)), 21'd0, 3'(f)} | 32'(f));
            recv_idle_pct = (f == 3) ? 0 : 36;
            send_idle_pct = (f == 3) ? 0 : 36;
            repeat (150) send_pixel(rand_pixel());
        end
        send_idle_pct = 36;
        recv_idle_pct = 36;
    endtask

    // Receiver holds off while pixels keep coming, so the input stalls;
    // then the sender pauses until everything has arrived.
    task automatic test_backpressure;
        write_format(32'(hprgba_pkg::FMT_RGBA_F16));
        hold_cycles = 40;
        recv_hold   = 1'b1;
        repeat (20) send_pixel(rand_pixel());
        wait_drained();
        repeat (100) send_pixel(rand_pixel());
    endtask

    // Receiver: random ready, plus a long counted hold-off when asked.
    always @(negedge i_clk) begin
        if (recv_hold) begin
            i_ready <= 1'b0;
            if (hold_cycles == 0) recv_hold <= 1'b0;
            else hold_cycles <= hold_cycles - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Checker: each output beat against the oldest expected beat.
    always @(posedge i_clk) begin
        hprgba_pkg::t_out_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rgba.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, o_data);
                fail_count++;
            end else begin
                want = pending_rgba.pop_front();
                if (o_data.red_out !== want.red_out) begin
                    $display("%0t: red expected %h actual %h", $time, want.red_out, o_data.red_out);
                    fail_count++;
                end
                if (o_data.green_out !== want.green_out) begin
                    $display("%0t: green expected %h actual %h", $time,
                             want.green_out, o_data.green_out);
                    fail_count++;
                end
                if (o_data.blue_out !== want.blue_out) begin
                    $display("%0t: blue expected %h actual %h", $time,
                             want.blue_out, o_data.blue_out);
                    fail_count++;
                end
                if (o_data.alpha_out !== want.alpha_out) begin
                    $display("%0t: alpha expected %h actual %h", $time,
                             want.alpha_out, o_data.alpha_out);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no beat moves on either side and psel is low.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        fail_count    = 0;
        idle_count    = 0;
        send_idle_pct = 36;
        recv_idle_pct = 36;
        recv_hold     = 1'b0;
        hold_cycles   = 0;
        cur_format    = hprgba_pkg::FMT_GBR_F32;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = 2'd0;
        pwdata  = 32'd0;
        i_valid = 1'b0;
        i_data  = '0;
        i_ready = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_halves();
        test_random_formats();
        test_backpressure();
        wait_drained();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
